### design/bmhq_pkg.sv
// shared types, constants and helpers for the binary min-heap queue
`default_nettype none
package bmhq_pkg;

	localparam int CAPACITY = 128;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 8;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CH_W     = IDX_W + 2;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		logic signed [31:0] min_value;
		logic [7:0]         count;
		status_t            status;
	} res_t;

	function automatic logic [COUNT_W-1:0] cnt_field(input logic [CNT_W-1:0] c);
		logic [CNT_W+COUNT_W-1:0] ext;
		ext = {{COUNT_W{1'b0}}, c};
		return ext[COUNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

### design/bmhq_ram.sv
// generic ram, one write port and two registered read ports
`default_nettype none
module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	output logic      [WIDTH-1:0]                         rdata_a,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic      [WIDTH-1:0]                         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

### design/binary_min_heap_queue.sv
// binary min-heap priority queue top level with sift sequencer
// a push climbs one heap level per memory read and a remove descends one level per read;
// refused requests, a push into an empty heap and a remove of the last entry need no sift.
// done rises in the cycle after the last memory write; busy is already low then.
// the receiver cannot stall; reset empties the heap, memory contents are left as they are.
`default_nettype none
module binary_min_heap_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire bmhq_pkg::req_t request,
	output logic               done,
	output bmhq_pkg::res_t     result
);
	import bmhq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_DN_LAST,
		S_DN,
		S_FIN
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] pos_q, pos_d;
	logic signed [DATA_W-1:0] hold_q, hold_d;
	logic signed [DATA_W-1:0] removed_q, removed_d;
	logic signed [DATA_W-1:0] root_q, root_d;

	logic we;
	logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
	logic [DATA_W-1:0] wdata, rdata_a, rdata_b;

	logic fin;
	status_t fin_status;
	logic signed [DATA_W-1:0] fin_removed;

	logic accept;
	logic [IDX_W-1:0] cnt_idx, cnt_pm1, pos_pm1, par, par_pm1;
	logic [CNT_W-1:0] cnt_m1;
	logic [CH_W-1:0] left, right, n_ext;
	logic [IDX_W-1:0] child;
	logic [IDX_W:0] gl, gr;
	logic signed [DATA_W-1:0] lval, rval, best_val;
	logic take_l, take_r;

	bmhq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign cnt_idx = cnt_q[IDX_W-1:0];
	assign cnt_pm1 = cnt_idx - IDX_W'(1);
	assign cnt_m1  = cnt_q - CNT_W'(1);
	assign pos_pm1 = pos_q - IDX_W'(1);
	assign par     = pos_pm1 >> 1;
	assign par_pm1 = par - IDX_W'(1);
	assign left    = {1'b0, pos_q, 1'b1};
	assign right   = left + CH_W'(1);
	assign n_ext   = {{(CH_W-CNT_W){1'b0}}, cnt_q};
	assign lval    = $signed(rdata_a);
	assign rval    = $signed(rdata_b);

	always_comb begin
		take_l   = (left < n_ext) && (lval < hold_q);
		best_val = take_l ? lval : hold_q;
		take_r   = (right < n_ext) && (rval < best_val);
		child    = take_r ? right[IDX_W-1:0] : left[IDX_W-1:0];
		gl       = {child, 1'b1};
		gr       = gl + (IDX_W+1)'(1);
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		pos_d       = pos_q;
		hold_d      = hold_q;
		removed_d   = removed_q;
		we          = 1'b0;
		waddr       = pos_q;
		wdata       = hold_q;
		raddr_a     = par_pm1 >> 1;
		raddr_b     = gr[IDX_W-1:0];
		fin         = 1'b0;
		fin_status  = ST_DONE;
		fin_removed = removed_q;
		unique case (state_q)
			S_IDLE: begin
				raddr_a = cnt_pm1 >> 1;
				if (accept) begin
					priority if (request.mode == MODE_PUSH) begin
						removed_d = '0;
						if (cnt_q >= CNT_W'(CAPACITY)) begin
							fin         = 1'b1;
							fin_status  = ST_FULL;
							fin_removed = '0;
						end else if (cnt_q == '0) begin
							we          = 1'b1;
							waddr       = '0;
							wdata       = request.value;
							cnt_d       = cnt_q + CNT_W'(1);
							fin         = 1'b1;
							fin_removed = '0;
						end else begin
							pos_d   = cnt_idx;
							hold_d  = request.value;
							cnt_d   = cnt_q + CNT_W'(1);
							state_d = S_UP;
						end
					end else begin
						if (cnt_q == '0) begin
							fin         = 1'b1;
							fin_status  = ST_EMPTY;
							fin_removed = '0;
						end else if (cnt_m1 == '0) begin
							cnt_d       = '0;
							fin         = 1'b1;
							fin_removed = root_q;
						end else begin
							raddr_a   = cnt_m1[IDX_W-1:0];
							removed_d = root_q;
							cnt_d     = cnt_m1;
							state_d   = S_DN_LAST;
						end
					end
				end
			end
			S_UP: begin
				if (lval > hold_q) begin
					we    = 1'b1;
					wdata = rdata_a;
					pos_d = par;
					if (par == '0) begin
						state_d = S_FIN;
					end
				end else begin
					we      = 1'b1;
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DN_LAST: begin
				hold_d  = lval;
				pos_d   = '0;
				raddr_a = IDX_W'(1);
				raddr_b = IDX_W'(2 % CAPACITY);
				state_d = S_DN;
			end
			S_DN: begin
				raddr_a = gl[IDX_W-1:0];
				we      = 1'b1;
				if (take_l || take_r) begin
					wdata = take_r ? rdata_b : rdata_a;
					pos_d = child;
				end else begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FIN: begin
				we      = 1'b1;
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		root_d = (we && waddr == '0) ? $signed(wdata) : root_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done    <= fin;
			if (fin) begin
				result.removed_value <= fin_removed;
				result.min_value     <= (cnt_d == '0) ? '0 : root_d;
				result.count         <= cnt_field(cnt_d);
				result.status        <= fin_status;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		hold_q    <= hold_d;
		removed_q <= removed_d;
		root_q    <= root_d;
	end

endmodule
`default_nettype wire

### dv/binary_min_heap_queue_tb.sv
// self-checking testbench for the binary min-heap queue: random push/remove traffic against a heap predictor
`timescale 1ns / 100ps
`default_nettype none
module binary_min_heap_queue_tb;
	import bmhq_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		req_t req;
		int   idle_pct;
	} pending_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	res_t result;

	pending_req_t req_backlog[$];
	res_t expected_res[$];
	logic signed [31:0] heap_mem[CAPACITY];
	int heap_len = 0;
	logic req_taken = 1'b0;
	int fail_count = 0;
	int cycle_count = 0;

	binary_min_heap_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// heap predictor, one result per request
	function automatic res_t heap_apply(req_t r);
		res_t e;
		int pos, up, lft, rgt, best;
		logic signed [31:0] t;
		e = '0;
		e.status = ST_DONE;
		if (r.mode == MODE_PUSH) begin
			if (heap_len >= CAPACITY) begin
				e.status = ST_FULL;
			end else begin
				heap_mem[heap_len] = r.value;
				pos = heap_len;
				heap_len++;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (heap_mem[up] <= heap_mem[pos])
						break;
					t = heap_mem[up];
					heap_mem[up] = heap_mem[pos];
					heap_mem[pos] = t;
					pos = up;
				end
			end
		end else if (heap_len == 0) begin
			e.status = ST_EMPTY;
		end else begin
			e.removed_value = heap_mem[0];
			heap_len--;
			heap_mem[0] = heap_mem[heap_len];
			pos = 0;
			forever begin
				lft = 2 * pos + 1;
				rgt = lft + 1;
				best = pos;
				if (lft < heap_len && heap_mem[lft] < heap_mem[best])
					best = lft;
				if (rgt < heap_len && heap_mem[rgt] < heap_mem[best])
					best = rgt;
				if (best == pos)
					break;
				t = heap_mem[pos];
				heap_mem[pos] = heap_mem[best];
				heap_mem[best] = t;
				pos = best;
			end
		end
		e.min_value = (heap_len > 0) ? heap_mem[0] : '0;
		e.count = 8'(heap_len);
		return e;
	endfunction

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom;
			5, 6, 7: return $signed($urandom_range(0, 8)) - 4;
			8: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	task automatic queue_req(logic m, logic signed [31:0] v, int pct);
		pending_req_t p;
		p.req.mode = m;
		p.req.value = v;
		p.idle_pct = pct;
		req_backlog.push_back(p);
	endtask

	// driver
	always @(negedge clk) begin
		pending_req_t nxt;
		if (arst_n && (!start || req_taken)) begin
			if (req_backlog.size() > 0 && $urandom_range(0, 99) >= req_backlog[0].idle_pct) begin
				nxt = req_backlog.pop_front();
				request <= nxt.req;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		res_t exp_res;
		if (arst_n) begin
			if (done) begin
				if (expected_res.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					exp_res = expected_res.pop_front();
					if (result.removed_value !== exp_res.removed_value) begin
						$error("removed_value: expected %0d, got %0d",
							exp_res.removed_value, result.removed_value);
						fail_count++;
					end
					if (result.min_value !== exp_res.min_value) begin
						$error("min_value: expected %0d, got %0d",
							exp_res.min_value, result.min_value);
						fail_count++;
					end
					if (result.count !== exp_res.count) begin
						$error("count: expected %0d, got %0d", exp_res.count, result.count);
						fail_count++;
					end
					if (result.status !== exp_res.status) begin
						$error("status: expected %0d, got %0d", exp_res.status, result.status);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				expected_res.push_back(heap_apply(request));
		end
		req_taken <= arst_n && start && !busy;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int phase_idle[4];
		int seg_left;
		int push_pct;
		int ph;
		int k;
		logic m;
		phase_idle = '{0, 54, 0, 15};
		seg_left = 0;
		push_pct = 50;

		// directed: empty remove, extremes, duplicates, drain past empty
		queue_req(MODE_POP, 32'sh1234_5678, 0);
		queue_req(MODE_PUSH, 32'sh0000_0000, 0);
		queue_req(MODE_PUSH, 32'sh7FFF_FFFF, 0);
		queue_req(MODE_PUSH, 32'sh8000_0000, 0);
		queue_req(MODE_PUSH, -32'sd1, 0);
		queue_req(MODE_PUSH, 32'sd1, 0);
		queue_req(MODE_PUSH, 32'sd5, 0);
		queue_req(MODE_PUSH, 32'sd5, 0);
		queue_req(MODE_PUSH, 32'sd5, 0);
		queue_req(MODE_PUSH, -32'sd1, 0);
		queue_req(MODE_PUSH, 32'sh8000_0000, 0);
		for (k = 0; k < 11; k++)
			queue_req(MODE_POP, $urandom, 0);
		queue_req(MODE_POP, 32'sh7FFF_FFFF, 0);
		queue_req(MODE_PUSH, -32'sd7, 0);
		queue_req(MODE_POP, -32'sd1, 0);

		// random: fill, drain and churn segments, so full and empty are both hit often
		for (ph = 0; ph < 4; ph++) begin
			for (k = 0; k < 490; k++) begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(20, 250);
					case ($urandom_range(0, 2))
						0: push_pct = 85;
						1: push_pct = 15;
						default: push_pct = 50;
					endcase
				end
				seg_left--;
				m = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
				queue_req(m, rand_value(), phase_idle[ph]);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_backlog.size() > 0 || start)
			@(posedge clk);
		while (expected_res.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
